@@ hdl/base32_stream_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// base32 stream encoder assertion macros
// concurrent checks on clk with rst_n low as the disable condition
// ----------------------------------------------------------------------------
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define B32ENC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define B32ENC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define B32ENC_ASSERT_IMPL(label, ante, cons, msg)
`define B32ENC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hdl/b32enc_pkg.sv @@
// ----------------------------------------------------------------------------
// b32enc_pkg
// shared types, constants and helpers of the base32 stream encoder
// ----------------------------------------------------------------------------
package b32enc_pkg;

  localparam int BYTE_W     = 8;
  localparam int LW_W       = 10;
  localparam int GROUP_W    = 40;
  localparam int CNT_W      = 3;
  localparam int NCH_W      = 4;
  localparam int IDX_W      = 3;
  localparam int DIGIT_W    = 5;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LW_W-1:0]   LW_RESET  = 10'd76;
  localparam logic [BYTE_W-1:0] CHAR_NL   = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_PAD  = 8'd61;
  localparam logic [NCH_W-1:0]  FULL_NCH  = 4'd8;
  localparam logic [CNT_W-1:0]  GROUP_MAX = 3'd4;

  // register index, taken from paddr bit 2
  localparam logic REG_LINE_WIDTH = 1'b0;

  // one group handed from the front to the back
  typedef struct packed {
    logic [GROUP_W-1:0] value;
    logic [NCH_W-1:0]   nchars;
    logic               eos;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } qpush_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic pop;
    logic pop_eos;
    logic col_zero;
    logic any_emitted;
  } bstat_t;

  // 5-bit digit to alphabet character: A-Z then 2-7
  function automatic logic [BYTE_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [BYTE_W-1:0] dx;
    dx = {3'b000, d};
    return (d < 5'd26) ? (dx + 8'd65) : (dx + 8'd24);
  endfunction

  // characters carried by a short group of k bytes
  function automatic logic [NCH_W-1:0] chars_for(input logic [CNT_W-1:0] k);
    logic [NCH_W-1:0] n;
    unique case (k)
      3'd1:    n = 4'd2;
      3'd2:    n = 4'd4;
      3'd3:    n = 4'd5;
      3'd4:    n = 4'd7;
      default: n = FULL_NCH;
    endcase
    return n;
  endfunction

endpackage

@@ hdl/b32enc_ifs.sv @@
// ----------------------------------------------------------------------------
// b32enc channel interfaces
// valid/ready byte input channel and character output channel
// ----------------------------------------------------------------------------
interface b32enc_in_if;
  import b32enc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface b32enc_out_if;
  import b32enc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_char;
  logic              last_out;

  modport source (output valid, output out_char, output last_out, input ready);
  modport sink   (input valid, input out_char, input last_out, output ready);
endinterface

@@ hdl/b32enc_front.sv @@
// ----------------------------------------------------------------------------
// b32enc_front
// collects input bytes into groups of five and queues a job per group
// ----------------------------------------------------------------------------
module b32enc_front (
  input  logic                clk,
  input  logic                rst_n,
  b32enc_in_if.sink           in_ch,
  input  b32enc_pkg::qstat_t  qstat,
  output b32enc_pkg::qpush_t  qpush
);
  import b32enc_pkg::*;

  logic [31:0]      bytes_r, bytes_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] k;
  logic [31:0]      grown;
  logic             accept;

  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign grown       = {bytes_r[23:0], in_ch.in_byte};
  assign k           = cnt_r + 3'd1;

  // group assembly and job issue
  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    qpush     = '0;
    if (accept) begin
      if (cnt_r >= GROUP_MAX) begin
        qpush.push       = 1'b1;
        qpush.job.value  = {bytes_r, in_ch.in_byte};
        qpush.job.nchars = FULL_NCH;
        qpush.job.eos    = in_ch.end_of_stream;
        bytes_nxt        = '0;
        cnt_nxt          = '0;
      end else begin
        bytes_nxt = grown;
        cnt_nxt   = k;
        if (in_ch.end_of_stream) begin
          qpush.push       = 1'b1;
          qpush.job.nchars = chars_for(k);
          qpush.job.eos    = 1'b1;
          // left-align the short group and zero-fill
          case (k)
            3'd1:    qpush.job.value = {grown[7:0], 32'd0};
            3'd2:    qpush.job.value = {grown[15:0], 24'd0};
            3'd3:    qpush.job.value = {grown[23:0], 16'd0};
            default: qpush.job.value = {grown, 8'd0};
          endcase
          bytes_nxt = '0;
          cnt_nxt   = '0;
        end
      end
    end
  end

  // group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= '0;
      cnt_r   <= '0;
    end else begin
      bytes_r <= bytes_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hdl/b32enc_queue.sv @@
// ----------------------------------------------------------------------------
// b32enc_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module b32enc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  b32enc_pkg::qpush_t  qpush,
  input  logic                pop,
  output b32enc_pkg::job_t    head,
  output b32enc_pkg::qstat_t  qstat
);
  import b32enc_pkg::*;

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign head        = mem_r[rd_ptr_r];
  assign qstat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign qstat.empty = (cnt_r == '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = qpush.push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({qpush.push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (qpush.push) begin
      mem_r[wr_ptr_r] <= qpush.job;
    end
  end

endmodule

@@ hdl/b32enc_back.sv @@
// ----------------------------------------------------------------------------
// b32enc_back
// serializes queued groups into characters, pads and line breaks
// ----------------------------------------------------------------------------
module b32enc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [b32enc_pkg::LW_W-1:0] line_width,
  input  b32enc_pkg::job_t        head,
  input  b32enc_pkg::qstat_t      qstat,
  output logic                    pop,
  b32enc_out_if.source            out_ch,
  output b32enc_pkg::bstat_t      bstat
);
  import b32enc_pkg::*;

  localparam logic [1:0] PH_CHAR = 2'd0;
  localparam logic [1:0] PH_NL   = 2'd1;
  localparam logic [1:0] PH_END  = 2'd2;

  logic [1:0]                    phase_r, phase_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [LW_W-1:0]               col_r, col_nxt;
  logic                          any_r, any_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]             char_r;
  logic                          last_r;
  logic [BYTE_W-1:0]             res_char;
  logic                          res_last;
  logic                          load;
  logic                          idx_last;
  logic                          wrap;
  logic                          wrap_on;
  logic [LW_W-1:0]               col_inc;
  logic [7:0][DIGIT_W-1:0]       digits;

  assign load     = !qstat.empty && (!out_valid_r || out_ch.ready);
  assign digits   = head.value;
  assign idx_last = (idx_r == 3'd7);
  assign col_inc  = col_r + 10'd1;
  assign wrap_on  = (line_width != '0);
  assign wrap     = wrap_on && ((col_inc >= line_width) || (col_inc == '0));

  // character sequencer
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    col_nxt   = col_r;
    any_nxt   = any_r;
    res_char  = CHAR_NL;
    res_last  = 1'b0;
    pop       = 1'b0;
    if (load) begin
      unique case (phase_r)
        PH_CHAR: begin
          res_char = ({1'b0, idx_r} < head.nchars) ? digit_char(digits[3'd7 - idx_r])
                                                    : CHAR_PAD;
          any_nxt = 1'b1;
          if (wrap_on) begin
            col_nxt = wrap ? '0 : col_inc;
          end
          if (wrap) begin
            any_nxt   = 1'b0;
            phase_nxt = PH_NL;
          end else if (idx_last) begin
            if (head.eos) begin
              phase_nxt = PH_END;
            end else begin
              res_last = 1'b1;
              pop      = 1'b1;
              idx_nxt  = '0;
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_NL: begin
          phase_nxt = PH_CHAR;
          if (idx_last) begin
            res_last = 1'b1;
            pop      = 1'b1;
            idx_nxt  = '0;
            if (head.eos) begin
              col_nxt = '0;
              any_nxt = 1'b0;
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_END: begin
          res_last  = 1'b1;
          pop       = 1'b1;
          idx_nxt   = '0;
          col_nxt   = '0;
          any_nxt   = 1'b0;
          phase_nxt = PH_CHAR;
        end
        default: begin
          phase_nxt = PH_CHAR;
        end
      endcase
    end
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CHAR;
      idx_r       <= '0;
      col_r       <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      col_r       <= col_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= res_char;
      last_r <= res_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = char_r;
  assign out_ch.last_out = last_r;

  assign bstat.pop         = pop;
  assign bstat.pop_eos     = pop && head.eos;
  assign bstat.col_zero    = (col_r == '0);
  assign bstat.any_emitted = any_r;

endmodule

@@ hdl/base32_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// base32_stream_encoder
// byte stream to base32 text with padding and line wrapping
// ----------------------------------------------------------------------------
// usage:
//   in_ch takes one byte per transaction, end_of_stream set on the final byte.
//   out_ch gives one character per transaction; last_out marks the final
//   character caused by an input byte. bytes that do not close a group give
//   no characters.
//   line_width (apb, byte address 0) sets characters per line, 0 = no wrap.
// timing:
//   a byte that closes a group or ends the stream passes through the job queue
//   and then the output register. the front takes one byte per cycle while
//   the two-entry job queue has room; the back emits one character per cycle
//   while out_ch.ready is high, so a five-byte group gives 8 characters plus
//   one per newline; the single character output register sets this pace.
// reset:
//   rst_n low clears the group, the queue, the line column and the output
//   register, and line_width returns to 76.
// stall:
//   when out_ch.ready is low the output register holds, the back stops, the
//   queue fills and in_ch.ready drops until the receiver takes characters.
// ----------------------------------------------------------------------------
`include "base32_stream_encoder_macros.svh"

module base32_stream_encoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  b32enc_in_if.sink                            in_ch,
  b32enc_out_if.source                         out_ch,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [b32enc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [b32enc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [b32enc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                 pready
);
  import b32enc_pkg::*;

  logic [LW_W-1:0] lw_r, lw_nxt;
  logic            reg_sel;
  qpush_t          qpush;
  qstat_t          qstat;
  job_t            head;
  logic            pop;
  bstat_t          bstat;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_LINE_WIDTH);
  assign prdata  = reg_sel ? {{(CFG_DATA_W-LW_W){1'b0}}, lw_r} : '0;

  always_comb begin
    lw_nxt = lw_r;
    if (psel && penable && pwrite && reg_sel) begin
      lw_nxt = pwdata[LW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= LW_RESET;
    end else begin
      lw_r <= lw_nxt;
    end
  end

  // front: byte grouping
  b32enc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .qpush (qpush)
  );

  // job queue
  b32enc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qpush (qpush),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // back: character output
  b32enc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_width (lw_r),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_ch     (out_ch),
    .bstat      (bstat)
  );

  // checks
  `B32ENC_ASSERT_IMPL(a_queue_no_overflow, qpush.push, !qstat.full, "job pushed into full queue")
  `B32ENC_ASSERT_IMPL(a_queue_no_underflow, pop, !qstat.empty, "job popped from empty queue")
  `B32ENC_ASSERT_NEXT(a_eos_clears_line, bstat.pop_eos, bstat.col_zero && !bstat.any_emitted, "line state not cleared at end of stream")

endmodule
